>>> rtl/core/mctb_pkg.sv
// Shared types, operation codes and defaults for the multi-channel timer bank.
package mctb_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int OP_W    = 3;
  localparam int SLOT_W  = 4;
  localparam int DUR_W   = 32;
  localparam int DELTA_W = 16;
  localparam int OUT_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_SET   = 3'd1,
    OP_RESET = 3'd2,
    OP_CLEAR = 3'd3,
    OP_CHECK = 3'd4,
    OP_READ  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_APPLY,
    ST_TICK,
    ST_TICK_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // take the input request into the item registers
    logic rd_slot;    // read the addressed slot
    logic rd_cnt;     // read the slot under the sweep counter
    logic apply;      // execute a single-slot operation and load its result
    logic tick_step;  // update the slot under the counter, fetch the next one
    logic tick_done;  // load the all-zero result of a tick
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic cnt_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/mctb_ctrl.sv
// Controller state machine that sequences single-slot operations and tick sweeps.
module mctb_ctrl
  import mctb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        if (status.is_tick) begin
          cmd.rd_cnt = 1'b1;
          state_next = ST_TICK;
        end else begin
          cmd.rd_slot = 1'b1;
          state_next  = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (status.out_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TICK: begin
        cmd.tick_step = 1'b1;
        if (status.cnt_last) begin
          state_next = ST_TICK_DONE;
        end
      end
      ST_TICK_DONE: begin
        if (status.out_free) begin
          cmd.tick_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/mctb_datapath.sv
// Slot storage, tick arithmetic, operation logic and result register.
module mctb_datapath
  import mctb_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [OP_W-1:0]    in_op,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [DUR_W-1:0]   in_duration,
  input  logic               in_repeat_req,
  input  logic [DELTA_W-1:0] in_delta,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ready_res,
  output logic               out_present,
  output logic [OUT_W-1:0]   out_elapsed,
  output logic [OUT_W-1:0]   out_duration
);

  localparam int AW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TW  = TIME_WIDTH;
  // Record layout: duration, elapsed, loop flag, ready flag from the low bits up.
  localparam int RW  = 2 * TW + 2;
  localparam int ELA_LO = TW;
  localparam int REP_B  = 2 * TW;
  localparam int RDY_B  = 2 * TW + 1;
  localparam int SW  = ((TW > DELTA_W) ? TW : DELTA_W) + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);

  // Item registers.
  logic [OP_W-1:0]    op_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TW-1:0]      dur_q;
  logic               rep_q;
  logic [DELTA_W-1:0] delta_q;

  // Slot storage.
  logic [RW-1:0]        mem [NUM_SLOTS];
  logic [RW-1:0]        rdata;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        rd_addr_q;
  logic                 rd_en;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [RW-1:0]        wr_data;
  logic [NUM_SLOTS-1:0] present_q;
  logic                 fresh0;

  logic [AW-1:0] cnt;
  logic          cnt_last;

  // Decoded view of the fetched record.
  logic [RW-1:0] rec;
  logic [TW-1:0] rec_dur;
  logic [TW-1:0] rec_ela;
  logic          rec_rep;
  logic          rec_rdy;

  logic [AW-1:0] slot_idx;
  logic          slot_ok;
  logic          slot_pres;

  logic [SW-1:0] sum;
  logic [TW-1:0] sum_sat;
  logic          tick_active;

  logic          set_present;
  logic          clr_present;
  logic          res_ready;
  logic          res_present;
  logic [TW-1:0] res_elapsed;
  logic [TW-1:0] res_duration;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= in_op;
      slot_q  <= in_slot;
      dur_q   <= TW'(in_duration);
      rep_q   <= in_repeat_req;
      delta_q <= in_delta;
    end
  end

  assign slot_idx = AW'(slot_q);
  assign slot_ok  = (32'(slot_q) < NUM_SLOTS);
  assign cnt_last = (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      cnt <= '0;
    end else if (cmd.tick_step && !cnt_last) begin
      cnt <= cnt + AW'(1);
    end
  end

  assign status.is_tick  = (op_q == OP_TICK);
  assign status.cnt_last = cnt_last;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    rd_en   = cmd.rd_slot || cmd.rd_cnt || (cmd.tick_step && !cnt_last);
    rd_addr = cmd.rd_slot ? slot_idx : (cmd.rd_cnt ? cnt : cnt + AW'(1));
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Slot 0 exists from reset with all-zero contents until its entry is written.
  assign rec     = (fresh0 && rd_addr_q == '0) ? '0 : rdata;
  assign rec_dur = rec[TW-1:0];
  assign rec_ela = rec[ELA_LO +: TW];
  assign rec_rep = rec[REP_B];
  assign rec_rdy = rec[RDY_B];

  assign slot_pres = slot_ok && present_q[slot_idx];

  // Saturating tick update.
  assign sum         = SW'(rec_ela) + SW'(delta_q);
  assign sum_sat     = (|sum[SW-1:TW]) ? {TW{1'b1}} : sum[TW-1:0];
  assign tick_active = present_q[cnt] && (rec_dur != '0);

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = slot_idx;
    wr_data      = rec;
    set_present  = 1'b0;
    clr_present  = 1'b0;
    res_ready    = 1'b0;
    res_present  = 1'b0;
    res_elapsed  = '0;
    res_duration = '0;
    if (cmd.tick_step) begin
      wr_en   = tick_active;
      wr_addr = cnt;
      wr_data = {(sum_sat >= rec_dur), rec_rep, sum_sat, rec_dur};
    end else if (cmd.apply) begin
      unique case (op_q)
        OP_SET: begin
          if (slot_ok) begin
            wr_en        = 1'b1;
            wr_data      = {slot_pres && rec_rdy, rep_q, dur_q, dur_q};
            set_present  = 1'b1;
            res_present  = 1'b1;
            res_elapsed  = dur_q;
            res_duration = dur_q;
          end
        end
        OP_RESET: begin
          if (slot_pres) begin
            wr_en        = 1'b1;
            wr_data      = {1'b0, rec_rep, {TW{1'b0}}, rec_dur};
            res_present  = 1'b1;
            res_duration = rec_dur;
          end
        end
        OP_CLEAR: begin
          clr_present = slot_ok;
        end
        OP_CHECK: begin
          if (slot_pres) begin
            wr_en        = rec_rep && rec_rdy;
            wr_data      = {rec_rdy, rec_rep, {TW{1'b0}}, rec_dur};
            res_ready    = rec_rdy;
            res_present  = 1'b1;
            res_elapsed  = (rec_rep && rec_rdy) ? '0 : rec_ela;
            res_duration = rec_dur;
          end
        end
        OP_READ: begin
          if (slot_pres) begin
            res_ready    = rec_rdy;
            res_present  = 1'b1;
            res_elapsed  = rec_ela;
            res_duration = rec_dur;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_q <= NUM_SLOTS'(1);
      fresh0    <= 1'b1;
    end else begin
      if (set_present) begin
        present_q[slot_idx] <= 1'b1;
      end else if (clr_present) begin
        present_q[slot_idx] <= 1'b0;
      end
      if (wr_en && wr_addr == '0) begin
        fresh0 <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply || cmd.tick_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply || cmd.tick_done) begin
      out_ready_res <= res_ready;
      out_present   <= res_present;
      out_elapsed   <= OUT_W'(res_elapsed);
      out_duration  <= OUT_W'(res_duration);
    end
  end

endmodule

>>> rtl/core/multi_channel_timer_bank.sv
// Top level of the multi-channel timer bank: stream ports, controller and datapath.
//
//  Channel  Direction  Bits (tdata)  Contents
//  s_*      request    56, tuser 3   operation, slot, duration, loop flag, tick delta
//  m_*      result     72            ready flag, present flag, elapsed count, duration
//
// A tick sweeps every slot through one memory port, one slot per cycle, before
// its result is loaded. Set, reset, clear, check and read pass through accept,
// slot fetch and execute in turn.
// Requests are taken one at a time; a new request is accepted while the last
// result still waits in the output register. A stalled result holds the next
// operation at its final step. After reset only slot 0 exists, with zero counts.
module multi_channel_timer_bank
  import mctb_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] slot, [35:4] duration, [36] repeat_req, [52:37] delta, [55:53] zero
  input  logic [55:0] s_tdata,
  // [2:0] op
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] ready_res, [1] present, [33:2] elapsed_out, [65:34] set_duration,
  // [71:66] zero
  output logic [71:0] m_tdata
);

  cmd_t    cmd;
  status_t status;

  logic              res_ready;
  logic              res_present;
  logic [OUT_W-1:0]  res_elapsed;
  logic [OUT_W-1:0]  res_duration;

  // The controller only steps the sequence; all slot state lives in the datapath.
  mctb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mctb_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_op         (s_tuser),
    .in_slot       (s_tdata[3:0]),
    .in_duration   (s_tdata[35:4]),
    .in_repeat_req (s_tdata[36]),
    .in_delta      (s_tdata[52:37]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_ready_res (res_ready),
    .out_present   (res_present),
    .out_elapsed   (res_elapsed),
    .out_duration  (res_duration)
  );

  // Pack the result fields from the lowest bit up, padded to whole bytes.
  assign m_tdata = {6'b0, res_duration, res_elapsed, res_present, res_ready};

endmodule

>>> tb/sv/timer_bank_checker.sv
`timescale 1ns / 1ps
// Result checker for the timer bank: predicts every result from the requests it sees.
module timer_bank_checker
  import mctb_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  output int unsigned failures,
  output int unsigned reports_owed
);

  typedef struct packed {
    logic [OUT_W-1:0] set_duration;
    logic [OUT_W-1:0] elapsed_out;
    logic             present;
    logic             ready_res;
  } report_t;

  logic             slot_live  [NUM_SLOTS];
  logic [DUR_W-1:0] slot_len   [NUM_SLOTS];
  logic [DUR_W-1:0] slot_count [NUM_SLOTS];
  logic             slot_loop  [NUM_SLOTS];
  logic             slot_done  [NUM_SLOTS];

  report_t     reports_due[$];
  int unsigned fail_count;
  int unsigned results_seen;

  function automatic void wipe_slot(input int unsigned idx);
    slot_live[idx]  = 1'b0;
    slot_len[idx]   = '0;
    slot_count[idx] = '0;
    slot_loop[idx]  = 1'b0;
    slot_done[idx]  = 1'b0;
  endfunction

  // Applies one request to the bank copy and returns the result it produces.
  function automatic report_t timer_bank_apply(input logic [OP_W-1:0] op,
                                               input logic [SLOT_W-1:0] slot,
                                               input logic [DUR_W-1:0] dur,
                                               input logic loop_flag,
                                               input logic [DELTA_W-1:0] delta);
    report_t   rpt;
    logic      hit;
    logic [DUR_W:0] sum;
    rpt = '0;
    hit = 1'b0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_live[i] && slot_len[i] != '0) begin
            sum = {1'b0, slot_count[i]} + {{(DUR_W + 1 - DELTA_W){1'b0}}, delta};
            slot_count[i] = sum[DUR_W] ? '1 : sum[DUR_W-1:0];
            slot_done[i] = (slot_count[i] >= slot_len[i]);
          end
        end
      end
      OP_SET: begin
        if (!slot_live[slot]) begin
          wipe_slot(32'(slot));
          slot_live[slot] = 1'b1;
        end
        slot_len[slot]   = dur;
        slot_count[slot] = dur;
        slot_loop[slot]  = loop_flag;
        hit = 1'b1;
      end
      OP_RESET: begin
        if (slot_live[slot]) begin
          slot_done[slot]  = 1'b0;
          slot_count[slot] = '0;
        end
        hit = 1'b1;
      end
      OP_CLEAR: begin
        wipe_slot(32'(slot));
        hit = 1'b1;
      end
      OP_CHECK: begin
        if (slot_live[slot]) begin
          if (slot_loop[slot] && slot_done[slot]) slot_count[slot] = '0;
          rpt.ready_res = slot_done[slot];
        end
        hit = 1'b1;
      end
      OP_READ: begin
        if (slot_live[slot]) rpt.ready_res = slot_done[slot];
        hit = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if (hit && slot_live[slot]) begin
      rpt.present      = 1'b1;
      rpt.elapsed_out  = slot_count[slot];
      rpt.set_duration = slot_len[slot];
    end else begin
      rpt.ready_res = 1'b0;
    end
    return rpt;
  endfunction

  always @(posedge clk) begin : watch
    report_t want;
    report_t got;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) wipe_slot(i);
      slot_live[0] = 1'b1;
      reports_due.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // Results leave before the request taken at the same edge is predicted.
      if (m_tvalid && m_tready) begin
        got.ready_res    = m_tdata[0];
        got.present      = m_tdata[1];
        got.elapsed_out  = m_tdata[33:2];
        got.set_duration = m_tdata[65:34];
        if (reports_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result %0d arrived with none outstanding", $realtime, results_seen);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          if (got.ready_res != want.ready_res || got.present != want.present ||
              got.elapsed_out != want.elapsed_out ||
              got.set_duration != want.set_duration) begin
            if (fail_count < 10)
              $display({"%0t: result %0d exp rdy=%0b pres=%0b elap=%h dur=%h,",
                        " got rdy=%0b pres=%0b elap=%h dur=%h"},
                       $realtime, results_seen, want.ready_res, want.present,
                       want.elapsed_out, want.set_duration, got.ready_res,
                       got.present, got.elapsed_out, got.set_duration);
            fail_count++;
          end
        end
        results_seen++;
      end
      if (s_tvalid && s_tready)
        reports_due.push_back(timer_bank_apply(s_tuser, s_tdata[3:0], s_tdata[35:4],
                                               s_tdata[36], s_tdata[52:37]));
    end
    failures     <= fail_count;
    reports_owed <= reports_due.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the timer bank: clock, reset, request stimulus, result stalls, verdict.
module tb;
  import mctb_pkg::*;

  // The two op codes that the encoding leaves unused; the bank must answer
  // them with an all-zero result and change nothing.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // The drain wait is sized from the slot count so that it covers one tick sweep.
  localparam int DRAIN_CYCLES    = NUM_SLOTS_DEF + 8;
  // Cycles with no handshake on either side before the run is abandoned.
  // The worst honest case is a tick behind a long random stall, well below this.
  localparam int QUIET_LIMIT     = 5000;
  localparam int RANDOM_REQUESTS = 1728;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;   // [3:0] slot, [35:4] duration, [36] repeat_req, [52:37] delta
  logic [2:0]  s_tuser;   // [2:0] op
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // [0] ready_res, [1] present, [33:2] elapsed_out, [65:34] set_duration

  int unsigned failures;
  int unsigned reports_owed;

  // Percent chance per cycle that the sender holds back or the receiver stalls.
  int unsigned idle_pct;
  int unsigned stall_pct;

  multi_channel_timer_bank i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  timer_bank_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .failures     (failures),
    .reports_owed (reports_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The result side decides its tready afresh at every falling edge.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a run that stops moving is a failure rather than a hang.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Presents one request and returns at the falling edge after it is taken.
  // Called at a falling edge, so tvalid gets a single assignment per step and
  // stays high across back-to-back requests.
  task automatic issue(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                       input logic [DUR_W-1:0] dur, input logic loop_flag,
                       input logic [DELTA_W-1:0] delta);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, delta, loop_flag, dur, slot};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // One random request. Most slots land in a small group so that sets, ticks
  // and checks meet on the same timers; durations and deltas mix tiny values,
  // values near the top of the range and fully random ones.
  task automatic random_request();
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [SLOT_W-1:0] slot;
    logic [DUR_W-1:0] dur;
    logic [DELTA_W-1:0] delta;
    pick = $urandom_range(99);
    if (pick < 25)      op = OP_TICK;
    else if (pick < 45) op = OP_SET;
    else if (pick < 57) op = OP_RESET;
    else if (pick < 64) op = OP_CLEAR;
    else if (pick < 84) op = OP_CHECK;
    else                op = OP_READ;
    slot = ($urandom_range(99) < 70) ? SLOT_W'($urandom_range(5))
                                     : SLOT_W'($urandom_range(15));
    case ($urandom_range(5))
      0:       dur = '0;
      1:       dur = $urandom_range(64, 1);
      2:       dur = $urandom_range(1000);
      3:       dur = ~$urandom_range(2000);
      default: dur = $urandom();
    endcase
    case ($urandom_range(3))
      0:       delta = DELTA_W'($urandom_range(16));
      1:       delta = DELTA_W'($urandom_range(300));
      2:       delta = DELTA_W'(~$urandom_range(64));
      default: delta = DELTA_W'($urandom());
    endcase
    issue(op, slot, dur, 1'($urandom_range(1)), delta);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, run without idling.
    issue(OP_READ,  4'd0,  32'd0, 1'b0, 16'd0);         // slot 0 exists after reset
    issue(OP_READ,  4'd5,  32'd0, 1'b0, 16'd0);         // absent slot reads as zeros
    issue(OP_RESET, 4'd5,  32'd0, 1'b0, 16'd0);         // reset of an absent slot is ignored
    issue(OP_CHECK, 4'd5,  32'd0, 1'b0, 16'd0);
    issue(OP_TICK,  4'd0,  32'd0, 1'b0, 16'hFFFF);      // zero duration: slot 0 does not move
    issue(OP_SET,   4'd15, 32'hFFFF_FFFF, 1'b1, 16'd0);
    issue(OP_TICK,  4'd9,  32'd0, 1'b0, 16'hFFFF);      // elapsed count saturates
    issue(OP_READ,  4'd15, 32'd0, 1'b0, 16'd0);
    issue(OP_CHECK, 4'd15, 32'd0, 1'b0, 16'd0);         // looping and ready: elapsed restarts
    issue(OP_SET,   4'd3,  32'd100, 1'b0, 16'd0);
    issue(OP_RESET, 4'd3,  32'd0, 1'b0, 16'd0);
    issue(OP_TICK,  4'd0,  32'd0, 1'b0, 16'd40);
    issue(OP_CHECK, 4'd3,  32'd0, 1'b0, 16'd0);         // not yet ready
    issue(OP_TICK,  4'd0,  32'd0, 1'b0, 16'd60);        // reaches the duration exactly
    issue(OP_CHECK, 4'd3,  32'd0, 1'b0, 16'd0);         // ready, one-shot keeps its count
    issue(OP_CLEAR, 4'd3,  32'd0, 1'b0, 16'd0);
    issue(OP_READ,  4'd3,  32'd0, 1'b0, 16'd0);
    issue(OP_SET,   4'd3,  32'd0, 1'b1, 16'd0);         // set after clear starts from defaults
    issue(OP_TICK,  4'd0,  32'd0, 1'b0, 16'd5);
    issue(OP_READ,  4'd3,  32'd0, 1'b0, 16'd0);
    issue(OP_CLEAR, 4'd0,  32'd0, 1'b0, 16'd0);         // slot 0 can be removed too
    issue(OP_READ,  4'd0,  32'd0, 1'b0, 16'd0);
    issue(OP_SPARE_LO, 4'd15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    issue(OP_SPARE_HI, 4'd3,  32'hA5A5_5A5A, 1'b1, 16'h5A5A);
    issue(OP_SET,   4'd0,  32'd1, 1'b0, 16'd0);

    // Random part in four phases: free flow, a slow sender, a slow receiver,
    // and light idling on both sides together.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 88; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      for (int n = 0; n < RANDOM_REQUESTS / 4; n++) random_request();
    end

    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (reports_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && reports_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
